[hdl/dbp_pkg.sv]
`timescale 1ns / 1ps

package dbp_pkg;

  // Fixed field widths
  localparam int unsigned QW       = 8;   // quantized input field
  localparam int unsigned SCALE_W  = 20;  // Q0.20 scale, threshold and score
  localparam int unsigned SCORE_W  = 20;
  localparam int unsigned CLS_W    = 6;
  localparam int unsigned MS_W     = 13;  // model size
  localparam int unsigned INV_W    = 20;  // Q8.12 inverse scale
  localparam int unsigned PACK_W   = 24;  // pad and frame register width
  localparam int unsigned MASK_W   = 64;
  localparam int unsigned CFG_W    = 64;  // config write data
  localparam int unsigned CFG_IDX_W = 3;

  // Internal arithmetic widths
  localparam int unsigned DQ_W   = 30;  // (q - zp) * scale, signed Q.20
  localparam int unsigned MP_W   = 43;  // model pixel, signed Q.20
  localparam int unsigned LO_W   = 22;  // low slice of model pixel for split product
  localparam int unsigned HI_W   = MP_W - LO_W;
  localparam int unsigned F_W    = 64;  // frame pixel, signed Q.32
  localparam int unsigned FRAC_W = 20;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZP         = 3'd0,
    CFG_QSCALE     = 3'd1,
    CFG_THRESHOLD  = 3'd2,
    CFG_CLASS_MASK = 3'd3,
    CFG_MODEL_SIZE = 3'd4,
    CFG_PAD        = 3'd5,
    CFG_INV_SCALE  = 3'd6,
    CFG_FRAME      = 3'd7
  } cfg_idx_e;

  // Dequantize one field: (q - zp) * scale
  function automatic logic signed [DQ_W-1:0] dequant(
    input logic signed [QW-1:0]    q,
    input logic signed [QW-1:0]    zp,
    input logic        [SCALE_W-1:0] scale
  );
    logic signed [QW:0]      diff;
    logic signed [SCALE_W:0] sc;
    diff = {q[QW-1], q} - {zp[QW-1], zp};
    sc   = $signed({1'b0, scale});
    return DQ_W'(diff) * DQ_W'(sc);
  endfunction

endpackage

[hdl/dbp_if.sv]
`timescale 1ns / 1ps

// Detection item channel
interface dbp_det_if
  import dbp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] left_q;
  logic signed [QW-1:0] top_q;
  logic signed [QW-1:0] right_q;
  logic signed [QW-1:0] bottom_q;
  logic signed [QW-1:0] score_q;
  logic signed [QW-1:0] class_q;

  modport source (output valid, left_q, top_q, right_q, bottom_q, score_q, class_q,
                  input ready);
  modport sink   (input valid, left_q, top_q, right_q, bottom_q, score_q, class_q,
                  output ready);
endinterface

// Box item channel
interface dbp_box_if
  import dbp_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] box_x;
  logic [COORD_BITS-1:0] box_y;
  logic [COORD_BITS-1:0] box_width;
  logic [COORD_BITS-1:0] box_height;
  logic [SCORE_W-1:0]    box_score;
  logic [CLS_W-1:0]      box_class;

  modport source (output valid, box_x, box_y, box_width, box_height, box_score, box_class,
                  input ready);
  modport sink   (input valid, box_x, box_y, box_width, box_height, box_score, box_class,
                  output ready);
endinterface

[hdl/detection_box_postprocess.sv]
`timescale 1ns / 1ps

// Detection box post-processing. Each detection item (four int8 corners,
// score, class) is dequantized, filtered on score threshold, class range and
// class mask, mapped from normalized coordinates through the letterbox into
// frame pixels, clamped and rounded; boxes of width or height 1 or less are
// dropped, so an item yields zero or one box. The pipeline takes one item per
// clock while the output is not stalled and has seven register stages, the
// last of which is the output register. The depth is set by the corner lanes,
// where the model-pixel times inverse-scale product is split into two partial
// products over two stages.
// Dropped items leave bubbles that later items close up, and a stalled output
// holds the pipeline stage by stage without losing items. Configuration
// registers are read live and are to be written only while the block is idle.
module detection_box_postprocess
  import dbp_pkg::*;
#(
  parameter int unsigned CLASS_COUNT = 64,
  parameter int unsigned COORD_BITS  = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  dbp_det_if.sink              det_i,
  dbp_box_if.source            box_o
);

  localparam int unsigned C_W  = COORD_BITS + 32;
  localparam int unsigned DX_W = C_W + 1;
  localparam int unsigned NST  = 7;
  localparam int unsigned CW_W = DQ_W + 1 - FRAC_W;  // rounded class magnitude

  // Configuration registers
  logic signed [QW-1:0] zp_q;
  logic [SCALE_W-1:0]   qscale_q;
  logic [SCALE_W-1:0]   thresh_q;
  logic [MASK_W-1:0]    cmask_q;
  logic [MS_W-1:0]      msize_q;
  logic [PACK_W-1:0]    pad_q;
  logic [INV_W-1:0]     inv_q;
  logic [PACK_W-1:0]    frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zp_q     <= '0;
      qscale_q <= SCALE_W'(4112);
      thresh_q <= SCALE_W'(524288);
      cmask_q  <= '1;
      msize_q  <= MS_W'(640);
      pad_q    <= '0;
      inv_q    <= INV_W'(4096);
      frame_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ZP:         zp_q     <= $signed(cfg_data_i[QW-1:0]);
        CFG_QSCALE:     qscale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_THRESHOLD:  thresh_q <= cfg_data_i[SCALE_W-1:0];
        CFG_CLASS_MASK: cmask_q  <= cfg_data_i[MASK_W-1:0];
        CFG_MODEL_SIZE: msize_q  <= cfg_data_i[MS_W-1:0];
        CFG_PAD:        pad_q    <= cfg_data_i[PACK_W-1:0];
        CFG_INV_SCALE:  inv_q    <= cfg_data_i[INV_W-1:0];
        CFG_FRAME:      frame_q  <= cfg_data_i[PACK_W-1:0];
        default: ;
      endcase
    end
  end

  // Split pad and frame into x and y parts
  logic [PACK_W-1:0]     pad_hi, frame_hi;
  logic [COORD_BITS-1:0] pad_l, pad_t, fw, fh;

  assign pad_hi   = pad_q >> COORD_BITS;
  assign frame_hi = frame_q >> COORD_BITS;
  assign pad_l    = pad_q[COORD_BITS-1:0];
  assign pad_t    = pad_hi[COORD_BITS-1:0];
  assign fw       = frame_q[COORD_BITS-1:0];
  assign fh       = frame_hi[COORD_BITS-1:0];

  // Stage valid bits and backpressure
  logic [NST:1]   v_q;
  logic [NST:1]   v_d;
  logic [NST+1:1] rdy;
  logic           keep;
  logic           box_ok;

  always_comb begin
    rdy[NST+1] = box_o.ready;
    for (int k = NST; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    v_d[1] = det_i.valid;
    for (int k = 2; k <= NST; k++) begin
      v_d[k] = v_q[k-1];
    end
    v_d[2]   = v_q[1] && keep;
    v_d[NST] = v_q[NST-1] && box_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign det_i.ready = rdy[1];

  // Corner lanes
  logic [C_W-1:0] x1, y1, x2, y2;

  dbp_corner #(.COORD_BITS(COORD_BITS)) u_left (
    .clk_i, .adv_i(rdy[5:1]), .q_i(det_i.left_q), .zp_i(zp_q), .scale_i(qscale_q),
    .model_size_i(msize_q), .pad_i(pad_l), .dim_i(fw), .inv_i(inv_q), .corner_o(x1)
  );
  dbp_corner #(.COORD_BITS(COORD_BITS)) u_top (
    .clk_i, .adv_i(rdy[5:1]), .q_i(det_i.top_q), .zp_i(zp_q), .scale_i(qscale_q),
    .model_size_i(msize_q), .pad_i(pad_t), .dim_i(fh), .inv_i(inv_q), .corner_o(y1)
  );
  dbp_corner #(.COORD_BITS(COORD_BITS)) u_right (
    .clk_i, .adv_i(rdy[5:1]), .q_i(det_i.right_q), .zp_i(zp_q), .scale_i(qscale_q),
    .model_size_i(msize_q), .pad_i(pad_l), .dim_i(fw), .inv_i(inv_q), .corner_o(x2)
  );
  dbp_corner #(.COORD_BITS(COORD_BITS)) u_bottom (
    .clk_i, .adv_i(rdy[5:1]), .q_i(det_i.bottom_q), .zp_i(zp_q), .scale_i(qscale_q),
    .model_size_i(msize_q), .pad_i(pad_t), .dim_i(fh), .inv_i(inv_q), .corner_o(y2)
  );

  // Score and class path
  logic signed [DQ_W-1:0] score_dq_q, class_dq_q;
  logic signed [DQ_W:0]   cls_t;
  logic [CW_W-1:0]        cls_wide;
  logic [CLS_W-1:0]       cls_d;
  logic [SCORE_W-1:0]     score_d;
  logic [SCORE_W-1:0]     score_p [2:NST];
  logic [CLS_W-1:0]       cls_p   [2:NST];

  always_comb begin
    cls_t    = (DQ_W+1)'(class_dq_q) + (DQ_W+1)'(1 << (FRAC_W - 1));
    cls_wide = cls_t[DQ_W:FRAC_W];
    cls_d    = cls_t[FRAC_W+CLS_W-1:FRAC_W];
    keep     = (score_dq_q > $signed({{(DQ_W-SCORE_W){1'b0}}, thresh_q}))
            && (cls_t > 0)
            && (cls_wide < CW_W'(CLASS_COUNT))
            && cmask_q[cls_d];
    score_d  = (score_dq_q > $signed(DQ_W'({SCORE_W{1'b1}})))
             ? {SCORE_W{1'b1}} : score_dq_q[SCORE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    // dequantize score and class
    if (rdy[1]) begin
      score_dq_q <= dequant(det_i.score_q, zp_q, qscale_q);
      class_dq_q <= dequant(det_i.class_q, zp_q, qscale_q);
    end
    // filter result and carry along
    if (rdy[2]) begin
      score_p[2] <= score_d;
      cls_p[2]   <= cls_d;
    end
    for (int k = 3; k <= NST; k++) begin
      if (rdy[k]) begin
        score_p[k] <= score_p[k-1];
        cls_p[k]   <= cls_p[k-1];
      end
    end
  end

  // Stage 6: round top-left, take extents
  logic [C_W-1:0]          x1_rnd, y1_rnd;
  logic [COORD_BITS-1:0]   bx_q, by_q;
  logic signed [DX_W-1:0]  dx_q, dy_q;

  assign x1_rnd = x1 + C_W'(64'd1 << 31);
  assign y1_rnd = y1 + C_W'(64'd1 << 31);

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      bx_q <= x1_rnd[C_W-1:32];
      by_q <= y1_rnd[C_W-1:32];
      dx_q <= $signed({1'b0, x2}) - $signed({1'b0, x1});
      dy_q <= $signed({1'b0, y2}) - $signed({1'b0, y1});
    end
  end

  // Stage 7: round size, drop thin boxes, output register
  logic signed [DX_W-1:0] w_sum, h_sum;
  logic [COORD_BITS-1:0]  w_d, h_d;
  logic [COORD_BITS-1:0]  bx_o_q, by_o_q, w_q, h_q;

  always_comb begin
    w_sum  = dx_q + DX_W'(64'd1 << 31);
    h_sum  = dy_q + DX_W'(64'd1 << 31);
    w_d    = w_sum[C_W-1:32];
    h_d    = h_sum[C_W-1:32];
    box_ok = (dx_q > 0) && (dy_q > 0)
          && (w_d > COORD_BITS'(1)) && (h_d > COORD_BITS'(1));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NST]) begin
      bx_o_q <= bx_q;
      by_o_q <= by_q;
      w_q    <= w_d;
      h_q    <= h_d;
    end
  end

  assign box_o.valid      = v_q[NST];
  assign box_o.box_x      = bx_o_q;
  assign box_o.box_y      = by_o_q;
  assign box_o.box_width  = w_q;
  assign box_o.box_height = h_q;
  assign box_o.box_score  = score_p[NST];
  assign box_o.box_class  = cls_p[NST];

endmodule

[hdl/dbp_corner.sv]
`timescale 1ns / 1ps

// One corner lane: dequantize, scale to model pixels, remove pad, map to
// frame pixels and clamp. Five register stages, each loaded by its own enable.
module dbp_corner
  import dbp_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                        clk_i,
  input  logic [4:0]                  adv_i,
  input  logic signed [QW-1:0]        q_i,
  input  logic signed [QW-1:0]        zp_i,
  input  logic [SCALE_W-1:0]          scale_i,
  input  logic [MS_W-1:0]             model_size_i,
  input  logic [COORD_BITS-1:0]       pad_i,
  input  logic [COORD_BITS-1:0]       dim_i,
  input  logic [INV_W-1:0]            inv_i,
  output logic [COORD_BITS+31:0]      corner_o
);

  localparam int unsigned C_W = COORD_BITS + 32;

  logic signed [DQ_W-1:0]      dq_q;
  logic signed [MP_W-1:0]      prod_q;
  logic signed [MP_W-1:0]      mp_q;
  logic [LO_W+INV_W-1:0]       pp_lo_q;
  logic signed [HI_W+INV_W:0]  pp_hi_q;
  logic [C_W-1:0]              corner_q;

  logic signed [MP_W-1:0]      pad_sh;
  logic signed [INV_W:0]       inv_s;
  logic signed [F_W-1:0]       frame_px;
  logic [COORD_BITS-1:0]       dim_m1;
  logic [C_W-1:0]              hi_bound;
  logic signed [F_W-1:0]       hi_s;
  logic [C_W-1:0]              corner_d;

  assign pad_sh = $signed({{(MP_W-COORD_BITS-FRAC_W){1'b0}}, pad_i, {FRAC_W{1'b0}}});
  assign inv_s  = $signed({1'b0, inv_i});

  // Join the split product and clamp to the frame
  always_comb begin
    frame_px = (F_W'(pp_hi_q) <<< LO_W) + $signed({{(F_W-LO_W-INV_W){1'b0}}, pp_lo_q});
    dim_m1   = dim_i - COORD_BITS'(1);
    hi_bound = (dim_i == '0) ? '0 : {dim_m1, 32'd0};
    hi_s     = $signed({{(F_W-C_W){1'b0}}, hi_bound});
    if (frame_px[F_W-1]) begin
      corner_d = '0;
    end else if (frame_px > hi_s) begin
      corner_d = hi_bound;
    end else begin
      corner_d = frame_px[C_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    // dequantize
    if (adv_i[0]) begin
      dq_q <= dequant(q_i, zp_i, scale_i);
    end
    // scale to model pixels
    if (adv_i[1]) begin
      prod_q <= MP_W'(dq_q) * $signed({{(MP_W-MS_W){1'b0}}, model_size_i});
    end
    // remove pad
    if (adv_i[2]) begin
      mp_q <= prod_q - pad_sh;
    end
    // partial products of model pixel times inverse scale
    if (adv_i[3]) begin
      pp_lo_q <= (LO_W+INV_W)'(mp_q[LO_W-1:0]) * (LO_W+INV_W)'(inv_i);
      pp_hi_q <= (HI_W+INV_W+1)'($signed(mp_q[MP_W-1:LO_W])) * (HI_W+INV_W+1)'(inv_s);
    end
    // sum and clamp
    if (adv_i[4]) begin
      corner_q <= corner_d;
    end
  end

  assign corner_o = corner_q;

endmodule
